FILE: design/sem_pkg.sv
package sem_pkg;
    localparam int PIX_W = 24;
    localparam int SUM_W = 17;
    localparam logic [0:0] CMD_PIXEL = 1'b0;
    localparam logic [0:0] CMD_FLUSH = 1'b1;
    localparam logic [0:0] REG_WIDTH = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;
    localparam logic [7:0] SAT_MAX = 8'd255;

    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
        logic [7:0] c5;
        logic [7:0] c6;
        logic [7:0] c7;
        logic [7:0] c8;
    } win_ch_t;

    typedef struct packed {
        logic       valid;
        logic       last;
    } tag_t;
endpackage

FILE: design/sem_lane.sv
module sem_lane
    import sem_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  win_ch_t          win,
    output logic [SUM_W-1:0] sum
);
    logic signed [10:0] gx_reg;
    logic signed [10:0] gy_reg;
    logic signed [10:0] gx_next;
    logic signed [10:0] gy_next;
    logic [SUM_W-1:0]   sq_reg;
    logic [SUM_W-1:0]   sq_next;
    logic [20:0]        gx2;
    logic [20:0]        gy2;
    logic [21:0]        s22;

    always_comb
    begin
        gx_next = $signed({3'd0, win.c2}) + $signed({2'd0, win.c5, 1'b0}) + $signed({3'd0, win.c8})
                - $signed({3'd0, win.c0}) - $signed({2'd0, win.c3, 1'b0}) - $signed({3'd0, win.c6});
        gy_next = $signed({3'd0, win.c6}) + $signed({2'd0, win.c7, 1'b0}) + $signed({3'd0, win.c8})
                - $signed({3'd0, win.c0}) - $signed({2'd0, win.c1, 1'b0}) - $signed({3'd0, win.c2});
        gx2 = 21'(gx_reg * gx_reg);
        gy2 = 21'(gy_reg * gy_reg);
        s22 = {1'b0, gx2} + {1'b0, gy2};
        sq_next = (s22 > 22'd65535) ? 17'd65536 : s22[SUM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
            sq_reg <= sq_next;
        end
    end

    assign sum = sq_reg;
endmodule

FILE: design/sem_sqrt.sv
module sem_sqrt
    import sem_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [SUM_W-1:0] sum,
    output logic [7:0]       root
);
    // one root bit per stage, eight stages
    logic [SUM_W-1:0] s_reg    [0:8];
    logic [8:0]       r_reg    [0:8];
    logic [SUM_W-1:0] s_next   [1:8];
    logic [8:0]       r_next   [1:8];
    logic [7:0]       root_reg;
    logic [7:0]       root_next;
    logic [SUM_W:0]   lim;

    always_comb
    begin
        for (int i = 1; i <= 8; i++)
        begin
            logic [8:0]  t;
            logic [17:0] sq;
            t = r_reg[i-1] | (9'd1 << (8 - i));
            sq = 18'(t) * 18'(t);
            s_next[i] = s_reg[i-1];
            r_next[i] = (sq <= {1'b0, s_reg[i-1]}) ? t : r_reg[i-1];
        end
        lim = 18'(r_reg[8]) * 18'(r_reg[8]) + 18'(r_reg[8]);
        if (s_reg[8][SUM_W-1])
            root_next = SAT_MAX;
        else if ({1'b0, s_reg[8]} > lim)
            root_next = (r_reg[8] >= 9'd255) ? SAT_MAX : 8'(r_reg[8] + 9'd1);
        else
            root_next = (r_reg[8] > 9'd255) ? SAT_MAX : r_reg[8][7:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg[0] <= sum;
            r_reg[0] <= '0;
            for (int i = 1; i <= 8; i++)
            begin
                s_reg[i] <= s_next[i];
                r_reg[i] <= r_next[i];
            end
            root_reg <= root_next;
        end
    end

    assign root = root_reg;
endmodule

FILE: design/sobel_edge_magnitude_rgb.sv
// Sobel edge magnitude on an RGB pixel stream, one word per clock.
// in channel: in_valid/in_ready with cmd, red_in, green_in, blue_in.
// cmd 0 is a pixel, cmd 1 a flush word that drives out pending results.
// out channel: out_valid/out_ready with red/green/blue_edge, frame_end.
// cfg channel: cfg_valid/cfg_ready, cfg_index 0 width, 1 height.
// A result appears one line plus one pixel of input after its pixel;
// then it passes the window register, two lane stages for gradient
// and square, a ten stage rounded root per lane and the output register.
// One word per clock sustained while the receiver keeps taking results.
// The whole pipeline advances only while the output register is free,
// so a stalled receiver freezes the block and drops in_ready.
// Reset sets width 640, height 480 and clears counters and window;
// line stores are not cleared, the zero padding masks stale entries.
// Write configuration only while the block is idle.
module sobel_edge_magnitude_rgb
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red_edge,
    output logic [7:0]  green_edge,
    output logic [7:0]  blue_edge,
    output logic        frame_end,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int DW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = DW + HW;
    localparam int LAT = 13;

    logic [10:0]     fw_reg, fh_reg;
    logic [DW-1:0]   w;
    logic [HW-1:0]   h;
    logic [PW-1:0]   total;
    logic [PW-1:0]   pos_reg;
    logic [CW-1:0]   col_reg;
    logic [CW-1:0]   col_next;
    logic [RW-1:0]   orow_reg;
    logic [CW-1:0]   ocol_reg;
    logic [PIX_W-1:0] upper_mem [0:MAX_WIDTH-1];
    logic [PIX_W-1:0] middle_mem [0:MAX_WIDTH-1];
    logic [PIX_W-1:0] top_rd_reg, mid_rd_reg;
    logic [PIX_W-1:0] win_reg [0:8];
    logic [PIX_W-1:0] top, mid, pix;
    logic            adv, take, full, emit;
    logic            last;
    logic            out_valid_reg;
    tag_t            tag_reg [0:LAT-1];
    logic [7:0]      root [0:2];
    logic [7:0]      edge_reg [0:2];
    logic            fe_reg;
    logic [8:0]      ok;
    logic [8:0]      ok_reg;
    logic [PIX_W-1:0] w_reg [0:8];
    win_ch_t         lw [0:2];
    logic [SUM_W-1:0] sums [0:2];

    always_comb
    begin
        if (fw_reg < 11'd2)
            w = DW'(2);
        else if (int'(fw_reg) > MAX_WIDTH)
            w = DW'(MAX_WIDTH);
        else
            w = DW'(fw_reg);
        if (fh_reg < 11'd2)
            h = HW'(2);
        else if (int'(fh_reg) > MAX_HEIGHT)
            h = HW'(MAX_HEIGHT);
        else
            h = HW'(fh_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total <= PW'(640 * 480);
        else
            total <= PW'(w) * PW'(h);
    end

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;
    assign full      = pos_reg >= total;
    assign take      = in_valid && adv && !(cmd == CMD_FLUSH && !full);
    assign emit      = take && (pos_reg >= PW'(w) + PW'(1));
    assign pix       = full ? '0 : {blue_in, green_in, red_in};

    always_comb
    begin
        col_next = col_reg;
        if (cfg_valid)
            col_next = '0;
        else if (take)
        begin
            if (emit && last)
                col_next = '0;
            else if (col_reg == CW'(w - DW'(1)))
                col_next = '0;
            else
                col_next = col_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            col_reg <= '0;
        else
            col_reg <= col_next;
    end

    // line stores read one word ahead at the column the next word uses
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            upper_mem[col_reg]  <= mid_rd_reg;
            middle_mem[col_reg] <= pix;
        end
        if (take && col_next == col_reg)
        begin
            top_rd_reg <= mid_rd_reg;
            mid_rd_reg <= pix;
        end
        else
        begin
            top_rd_reg <= upper_mem[col_next];
            mid_rd_reg <= middle_mem[col_next];
        end
    end
    assign top = top_rd_reg;
    assign mid = mid_rd_reg;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            ok[i] = 1'b1;
            if (i / 3 == 0 && orow_reg == '0) ok[i] = 1'b0;
            if (i / 3 == 2 && RW'(orow_reg) == RW'(h - HW'(1))) ok[i] = 1'b0;
            if (i % 3 == 0 && ocol_reg == '0) ok[i] = 1'b0;
            if (i % 3 == 2 && ocol_reg == CW'(w - DW'(1))) ok[i] = 1'b0;
        end
    end

    assign last = (orow_reg == RW'(h - HW'(1))) && (ocol_reg == CW'(w - DW'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= 11'd640;
            fh_reg <= 11'd480;
            pos_reg <= '0;
            orow_reg <= '0;
            ocol_reg <= '0;
            for (int i = 0; i < 9; i++) win_reg[i] <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_WIDTH) fw_reg <= cfg_data;
            else fh_reg <= cfg_data;
            pos_reg <= '0;
            orow_reg <= '0;
            ocol_reg <= '0;
            for (int i = 0; i < 9; i++) win_reg[i] <= '0;
        end
        else if (take)
        begin
            if (emit && last)
            begin
                pos_reg <= '0;
                orow_reg <= '0;
                ocol_reg <= '0;
                for (int i = 0; i < 9; i++) win_reg[i] <= '0;
            end
            else
            begin
                pos_reg <= pos_reg + PW'(1);
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3]   <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                end
                win_reg[2] <= top;
                win_reg[5] <= mid;
                win_reg[8] <= pix;
                if (emit)
                begin
                    if (ocol_reg == CW'(w - DW'(1)))
                    begin
                        ocol_reg <= '0;
                        orow_reg <= orow_reg + RW'(1);
                    end
                    else
                        ocol_reg <= ocol_reg + CW'(1);
                end
            end
        end
    end

    // shifted window for the lanes, before zero masking
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                w_reg[r*3]   <= win_reg[r*3+1];
                w_reg[r*3+1] <= win_reg[r*3+2];
            end
            w_reg[2] <= top;
            w_reg[5] <= mid;
            w_reg[8] <= pix;
            ok_reg <= ok;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            lw[c].c0 = ok_reg[0] ? w_reg[0][8*c +: 8] : 8'd0;
            lw[c].c1 = ok_reg[1] ? w_reg[1][8*c +: 8] : 8'd0;
            lw[c].c2 = ok_reg[2] ? w_reg[2][8*c +: 8] : 8'd0;
            lw[c].c3 = ok_reg[3] ? w_reg[3][8*c +: 8] : 8'd0;
            lw[c].c5 = ok_reg[5] ? w_reg[5][8*c +: 8] : 8'd0;
            lw[c].c6 = ok_reg[6] ? w_reg[6][8*c +: 8] : 8'd0;
            lw[c].c7 = ok_reg[7] ? w_reg[7][8*c +: 8] : 8'd0;
            lw[c].c8 = ok_reg[8] ? w_reg[8][8*c +: 8] : 8'd0;
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        sem_lane u_lane (.clk(clk), .en(adv), .win(lw[c]), .sum(sums[c]));
        sem_sqrt u_sqrt (.clk(clk), .en(adv), .sum(sums[c]), .root(root[c]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++) tag_reg[i] <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            tag_reg[0] <= '{valid: emit && !cfg_valid, last: last};
            for (int i = 1; i < LAT; i++) tag_reg[i] <= tag_reg[i-1];
            out_valid_reg <= tag_reg[LAT-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++) edge_reg[c] <= root[c];
            fe_reg <= tag_reg[LAT-1].last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_edge   = edge_reg[0];
    assign green_edge = edge_reg[1];
    assign blue_edge  = edge_reg[2];
    assign frame_end  = fe_reg & out_valid_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_edge))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while stalled");
    a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= total + PW'(w) || $past(cfg_valid) || $past(!rst_n))
        else $error("position beyond frame");
endmodule
